// ===== rtl/ser_pkg.sv =====
// Package for the sequenced event ring: command and result structs, codes and
// constants shared by the front end, command queue, back end, top level and checker.
// No dependencies.
package ser_pkg;

  localparam int MAX_RESULTS = 64;

  // Configuration register indexes.
  localparam logic [7:0] CFG_ALLOW_MASK = 8'd0;
  localparam logic [7:0] CFG_MIN_POLL   = 8'd1;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_POLL  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_EVENT = 2'd0,
    OP_POLL  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_EVENT     = 2'd0,
    ST_NONE      = 2'd1,
    ST_THROTTLED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RANGE,
    BK_STATUS,
    BK_STREAM
  } bk_state_e;

  typedef struct packed {
    op_e         op;
    logic [4:0]  ev_type;
    logic [63:0] payload;
    logic [63:0] start_seq;
    logic [6:0]  want;
    logic [63:0] now_ms;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [4:0]  ev_type;
    logic [63:0] payload;
    logic        is_last;
    logic [63:0] oldest_seq;
    logic [63:0] next_seq;
    logic [6:0]  buffered;
    logic [63:0] dropped;
    logic [63:0] throttled;
  } result_t;

endpackage

// ===== rtl/sequenced_event_ring_core.sv =====
// Sequenced event ring top level: configuration registers, front end, command
// queue and back end. Depends on ser_pkg, ser_front, ser_queue and ser_back.
// Events and clears are handled as they are popped; a poll checks the throttle on pop
// and, unless throttled, goes through a range state before its results are issued,
// which then follow one per cycle while the output is not stalled.
// Reset empties the ring, zeroes counters and times, and restores register defaults.
module sequenced_event_ring_core import ser_pkg::*; #(
  parameter int RING_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [1:0]   s_tuser_i,    // kind
  // event_type[4:0], event_payload[68:5], start_seq[132:69], max_count[139:133],
  // now_ms[203:140], zero padding[207:204]
  input  logic [207:0] s_tdata_i,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic         m_tlast_o,    // last
  // status[1:0], out_type[6:2], out_payload[70:7], oldest_seq[134:71],
  // next_seq_out[198:135], buffered[205:199], dropped_total[269:206],
  // throttled_total[333:270], zero padding[335:334]
  output logic [335:0] m_tdata_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  logic [31:0] allow_q;
  logic [15:0] min_poll_q;

  logic    q_push, q_full, q_pop, q_valid;
  cmd_t    q_in, q_out;
  result_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_q    <= 32'hFFFF_FFFF;
      min_poll_q <= 16'd100;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ALLOW_MASK: allow_q    <= cfg_data_i;
        CFG_MIN_POLL:   min_poll_q <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  ser_front u_front (
    .s_tvalid_i   (s_tvalid_i),
    .s_tready_o   (s_tready_o),
    .s_tuser_i    (s_tuser_i),
    .s_tdata_i    (s_tdata_i),
    .allow_mask_i (allow_q),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (q_in)
  );

  ser_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_out)
  );

  ser_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_out),
    .pop_o       (q_pop),
    .min_poll_i  (min_poll_q),
    .res_valid_o (m_tvalid_o),
    .res_ready_i (m_tready_i),
    .res_o       (res)
  );

  assign m_tlast_o = res.is_last;
  assign m_tdata_o = {2'b00, res.throttled, res.dropped, res.buffered, res.next_seq,
                      res.oldest_seq, res.payload, res.ev_type, res.status};

endmodule

// ===== rtl/ser_front.sv =====
// Front end of the sequenced event ring: unpacks input transfers, applies the
// allow mask, saturates the poll limit and pushes commands. Depends on ser_pkg.
module ser_front import ser_pkg::*; (
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [1:0]   s_tuser_i,    // kind
  // event_type[4:0], event_payload[68:5], start_seq[132:69], max_count[139:133],
  // now_ms[203:140], zero padding[207:204]
  input  logic [207:0] s_tdata_i,
  input  logic [31:0]  allow_mask_i,
  input  logic         q_full_i,
  output logic         q_push_o,
  output cmd_t         q_cmd_o
);

  logic [6:0] max_count;
  logic       keep;

  assign max_count = s_tdata_i[139:133];

  always_comb begin
    q_cmd_o.ev_type   = s_tdata_i[4:0];
    q_cmd_o.payload   = s_tdata_i[68:5];
    q_cmd_o.start_seq = s_tdata_i[132:69];
    q_cmd_o.now_ms    = s_tdata_i[203:140];
    q_cmd_o.want      = (max_count > 7'(MAX_RESULTS)) ? 7'(MAX_RESULTS) : max_count;
    q_cmd_o.op        = OP_EVENT;
    keep              = 1'b0;
    unique case (s_tuser_i)
      KIND_EVENT: begin
        q_cmd_o.op = OP_EVENT;
        keep       = allow_mask_i[s_tdata_i[4:0]];
      end
      KIND_POLL: begin
        q_cmd_o.op = OP_POLL;
        keep       = 1'b1;
      end
      KIND_CLEAR: begin
        q_cmd_o.op = OP_CLEAR;
        keep       = 1'b1;
      end
      default: begin
        // Unknown kinds and masked events are taken and discarded here.
        keep = 1'b0;
      end
    endcase
  end

  assign s_tready_o = ~q_full_i;
  assign q_push_o   = s_tvalid_i & ~q_full_i & keep;

endmodule

// ===== rtl/ser_queue.sv =====
// Two-entry command queue between the front end and the back end of the
// sequenced event ring. Depends on ser_pkg.
module ser_queue import ser_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam logic [1:0] QueueFull = 2'd2;

  cmd_t       entry_q [2];
  logic [1:0] cnt_q;
  logic       wr_ptr_q;
  logic       rd_ptr_q;

  assign full_o  = (cnt_q == QueueFull);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= cmd_i;
  end

endmodule

// ===== rtl/ser_back.sv =====
// Back end of the sequenced event ring: ring memory, counters, poll sequencer
// and the two-stage result pipeline (memory read stage, output register).
// Depends on ser_pkg.
module ser_back import ser_pkg::*; #(
  parameter int RING_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  input  logic [15:0] min_poll_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output result_t     res_o
);

  localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FW = $clog2(RING_DEPTH + 1);
  localparam int MW = (FW > 7) ? FW : 7;
  localparam logic [FW-1:0] DepthF   = FW'(RING_DEPTH);
  localparam logic [FW:0]   DepthS   = (FW + 1)'(RING_DEPTH);
  localparam logic [IW-1:0] LastSlot = IW'(RING_DEPTH - 1);

  // Ring storage.
  logic [4:0]  type_mem    [RING_DEPTH];
  logic [63:0] payload_mem [RING_DEPTH];

  bk_state_e   state_q, state_d;
  logic [IW-1:0] head_q;
  logic [FW-1:0] fill_q;
  logic [63:0] seq_q, oldest_q, drop_q, thr_q, last_poll_q;

  // Poll working registers.
  logic [63:0]   start_q;
  logic [6:0]    want_q;
  logic          none_q;
  status_e       status_q;
  logic [IW-1:0] slot_q;
  logic [6:0]    remain_q;

  // Result pipeline.
  logic        rd_vld_q, out_vld_q;
  result_t     rd_res_q, out_res_q;
  result_t     rd_out;
  logic        rd_mem_q;
  logic [4:0]  rd_type_q;
  logic [63:0] rd_pay_q;

  logic          rd_move, iss_ok, issue_status, issue_mem, mem_we;
  logic          full, throttled;
  logic [IW-1:0] head_inc, slot_inc, wr_slot, wr_addr, slot0;
  logic [FW:0]   wsum, ssum;
  logic [64:0]   diff;
  logic [63:0]   start_clamp;
  logic [FW-1:0] offset, avail;
  logic [MW-1:0] avail_m, want_m, n_m;
  logic          range_none;

  assign rd_move = ~out_vld_q | res_ready_i;
  assign iss_ok  = ~rd_vld_q | rd_move;

  assign full     = (fill_q == DepthF);
  assign head_inc = (head_q == LastSlot) ? '0 : head_q + 1'b1;
  assign slot_inc = (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
  assign wsum     = (FW + 1)'(head_q) + (FW + 1)'(fill_q);
  assign wr_slot  = (wsum >= DepthS) ? IW'(wsum - DepthS) : IW'(wsum);
  // When full, the oldest slot is dropped and reused for the new event.
  assign wr_addr  = full ? head_q : wr_slot;

  // Throttle test without wrap: negative or short elapsed time.
  assign diff        = {1'b0, cmd_i.now_ms} - {1'b0, last_poll_q};
  assign throttled   = diff[64] | (diff[63:0] < 64'(min_poll_i));
  assign start_clamp = (cmd_i.start_seq < oldest_q) ? oldest_q : cmd_i.start_seq;

  // The clamped start lies inside the window here, so the low bits suffice.
  assign range_none = none_q | (start_q >= seq_q);
  assign offset     = start_q[FW-1:0] - oldest_q[FW-1:0];
  assign avail      = fill_q - offset;
  assign avail_m    = MW'(avail);
  assign want_m     = MW'(want_q);
  assign n_m        = (avail_m < want_m) ? avail_m : want_m;
  assign ssum       = (FW + 1)'(head_q) + (FW + 1)'(offset);
  assign slot0      = (ssum >= DepthS) ? IW'(ssum - DepthS) : IW'(ssum);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && cmd_i.op == OP_POLL) begin
          state_d = throttled ? BK_STATUS : BK_RANGE;
        end
      end
      BK_RANGE:  state_d = range_none ? BK_STATUS : BK_STREAM;
      BK_STATUS: if (iss_ok) state_d = BK_IDLE;
      BK_STREAM: if (iss_ok && remain_q == 7'd1) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o        = (state_q == BK_IDLE) & cmd_valid_i;
    issue_status = (state_q == BK_STATUS) & iss_ok;
    issue_mem    = (state_q == BK_STREAM) & iss_ok;
    mem_we       = pop_o & (cmd_i.op == OP_EVENT);
  end

  // The read stage result with the event fields taken from the memory read.
  always_comb begin
    rd_out         = rd_res_q;
    rd_out.ev_type = rd_mem_q ? rd_type_q : 5'd0;
    rd_out.payload = rd_mem_q ? rd_pay_q : 64'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      seq_q       <= '0;
      oldest_q    <= '0;
      drop_q      <= '0;
      thr_q       <= '0;
      last_poll_q <= '0;
      rd_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        unique case (cmd_i.op)
          OP_EVENT: begin
            if (full) begin
              head_q   <= head_inc;
              drop_q   <= drop_q + 64'd1;
              oldest_q <= oldest_q + 64'd1;
            end else begin
              fill_q <= fill_q + 1'b1;
            end
            seq_q <= seq_q + 64'd1;
          end
          OP_POLL: begin
            if (throttled) thr_q <= thr_q + 64'd1;
            else           last_poll_q <= cmd_i.now_ms;
          end
          OP_CLEAR: begin
            head_q   <= '0;
            fill_q   <= '0;
            oldest_q <= seq_q;
          end
          default: begin
          end
        endcase
      end
      if (issue_status || issue_mem) rd_vld_q <= 1'b1;
      else if (rd_move)              rd_vld_q <= 1'b0;
      if (rd_vld_q && rd_move) out_vld_q <= 1'b1;
      else if (res_ready_i)    out_vld_q <= 1'b0;
    end
  end

  // Ring memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      type_mem[wr_addr]    <= cmd_i.ev_type;
      payload_mem[wr_addr] <= cmd_i.payload;
    end
    if (issue_mem) begin
      rd_type_q <= type_mem[slot_q];
      rd_pay_q  <= payload_mem[slot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      start_q  <= start_clamp;
      want_q   <= cmd_i.want;
      none_q   <= (cmd_i.want == 7'd0) | (fill_q == '0);
      status_q <= ST_THROTTLED;
    end
    if (state_q == BK_RANGE) begin
      status_q <= ST_NONE;
      slot_q   <= slot0;
      remain_q <= n_m[6:0];
    end
    if (issue_mem) begin
      slot_q   <= slot_inc;
      remain_q <= remain_q - 7'd1;
    end
    // Counters are captured at issue so that later commands cannot disturb them.
    if (issue_status || issue_mem) begin
      rd_mem_q            <= issue_mem;
      rd_res_q.status     <= issue_mem ? ST_EVENT : status_q;
      rd_res_q.ev_type    <= '0;
      rd_res_q.payload    <= '0;
      rd_res_q.is_last    <= issue_status | (remain_q == 7'd1);
      rd_res_q.oldest_seq <= oldest_q;
      rd_res_q.next_seq   <= seq_q;
      rd_res_q.buffered   <= 7'(fill_q);
      rd_res_q.dropped    <= drop_q;
      rd_res_q.throttled  <= thr_q;
    end
    if (rd_vld_q && rd_move) begin
      out_res_q <= rd_out;
    end
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_res_q;

endmodule

// ===== rtl/ser_checker.sv =====
// Port-level checker for the sequenced event ring, bound to the top level.
// Depends on ser_pkg and sequenced_event_ring_core.
module ser_checker import ser_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_tvalid_o,
  input logic         m_tready_i,
  input logic         m_tlast_o,
  input logic [335:0] m_tdata_o
);

  logic [1:0]  status;
  logic [63:0] window;

  assign status = m_tdata_o[1:0];
  assign window = m_tdata_o[198:135] - m_tdata_o[134:71];

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tlast_o))
    else $error("result changed while stalled");

  // A status result is always the only and hence final result of its poll.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && status != ST_EVENT |-> m_tlast_o)
    else $error("status result without last");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && status != ST_EVENT |-> m_tdata_o[70:2] == 69'd0)
    else $error("status result carries event data");

  // The sequence window always spans exactly the buffered events.
  a_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> window[6:0] == m_tdata_o[205:199])
    else $error("sequence window disagrees with buffered count");

endmodule

bind sequenced_event_ring_core ser_checker u_ser_checker (.*);
